@@ sv/pl_pkg.sv @@
package pl_pkg;

  localparam int FUNC_W = 2;
  localparam int POS_W  = 8;
  localparam int VAL_W  = 32;
  localparam int FPOS_W = 7;
  localparam int CNT_W  = 8;

  // Operation codes; the fourth code has no member and falls to a default arm
  typedef enum logic [FUNC_W-1:0] {
    FUNC_SEARCH = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_DELETE = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_INS_CHK,
    ST_INS_WR,
    ST_DEL_CHK,
    ST_DEL_WR,
    ST_FINISH
  } state_t;

  // Source of the index load
  typedef enum logic [1:0] {
    IDX_ZERO,
    IDX_COUNT,
    IDX_POS
  } idx_sel_t;

  // Read address relative to the index
  typedef enum logic [1:0] {
    RD_HERE,
    RD_DOWN,
    RD_UP
  } rd_sel_t;

  // Write data source
  typedef enum logic {
    WR_VALUE,
    WR_READ
  } wr_sel_t;

  typedef struct packed {
    logic     load;
    logic     idx_set;
    idx_sel_t idx_sel;
    logic     idx_inc;
    logic     idx_dec;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wr_sel_t  wr_sel;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     res_set;
    logic     res_ok;
    logic     res_found;
    logic     out_load;
  } pl_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic              ins_ok;
    logic              del_ok;
    logic              cnt_zero;
    logic              idx_at_pos;
    logic              idx_last;
    logic              hit;
  } pl_status_t;

endpackage

@@ sv/pl_if.sv @@
interface pl_in_if;
  import pl_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [POS_W-1:0]  position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output func, output position, output value, input ready);
  modport sink   (input valid, input func, input position, input value, output ready);
endinterface

interface pl_out_if;
  import pl_pkg::*;
  logic              valid;
  logic              ready;
  logic              ok;
  logic [FPOS_W-1:0] found_position;
  logic [CNT_W-1:0]  count;

  modport source (output valid, output ok, output found_position, output count, input ready);
  modport sink   (input valid, input ok, input found_position, input count, output ready);
endinterface

@@ sv/pl_dpath.sv @@
module pl_dpath #(
  parameter int DEPTH = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pl_pkg::pl_cmd_t              cmd,
  output pl_pkg::pl_status_t           st,
  input  logic [pl_pkg::FUNC_W-1:0]    in_func,
  input  logic [pl_pkg::POS_W-1:0]     in_position,
  input  logic signed [pl_pkg::VAL_W-1:0] in_value,
  output logic                         out_ok,
  output logic [pl_pkg::FPOS_W-1:0]    out_found_position,
  output logic [pl_pkg::CNT_W-1:0]     out_count
);
  import pl_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [FUNC_W-1:0] op_r;
  logic [POS_W-1:0]  pos_r;
  logic [VAL_W-1:0]  val_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [VAL_W-1:0]  mem [DEPTH];
  logic [VAL_W-1:0]  rd_data_r;
  logic              res_ok_r;
  logic [FPOS_W-1:0] res_pos_r;
  logic              out_ok_r;
  logic [FPOS_W-1:0] out_pos_r;
  logic [CNT_W-1:0]  out_cnt_r;

  logic [31:0]       pos_ext, cnt_ext, idx_ext;
  logic [CW-1:0]     idx_m1, idx_p1;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [VAL_W-1:0]  wr_data;

  assign pos_ext = 32'(pos_r);
  assign cnt_ext = 32'(cnt_r);
  assign idx_ext = 32'(idx_r);
  assign idx_m1  = idx_r - CW'(1);
  assign idx_p1  = idx_r + CW'(1);

  // Status towards the controller
  assign st.op         = op_r;
  assign st.ins_ok     = (cnt_ext < 32'(DEPTH)) && (pos_ext <= cnt_ext);
  assign st.del_ok     = pos_ext < cnt_ext;
  assign st.cnt_zero   = cnt_ext == 32'd0;
  assign st.idx_at_pos = idx_ext == pos_ext;
  assign st.idx_last   = (idx_ext + 32'd1) >= cnt_ext;
  assign st.hit        = rd_data_r == val_r;

  // Capture the operation on its input beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_func;
      pos_r <= in_position;
      val_r <= in_value;
    end
  end

  // Walk index and element count
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_set) begin
      unique case (cmd.idx_sel)
        IDX_ZERO:  idx_nxt = '0;
        IDX_COUNT: idx_nxt = cnt_r;
        IDX_POS:   idx_nxt = pos_ext[CW-1:0];
        default:   idx_nxt = '0;
      endcase
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_p1;
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_m1;
    end
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  // Entry store: one write and one registered read per cycle
  always_comb begin
    unique case (cmd.rd_sel)
      RD_HERE: rd_addr = idx_r[AW-1:0];
      RD_DOWN: rd_addr = idx_m1[AW-1:0];
      RD_UP:   rd_addr = idx_p1[AW-1:0];
      default: rd_addr = idx_r[AW-1:0];
    endcase
  end

  assign wr_addr = idx_r[AW-1:0];
  assign wr_data = (cmd.wr_sel == WR_VALUE) ? val_r : rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Hold the pending result, then move it to the output register
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_ok_r  <= cmd.res_ok;
      res_pos_r <= cmd.res_found ? idx_ext[FPOS_W-1:0] : '0;
    end
    if (cmd.out_load) begin
      out_ok_r  <= res_ok_r;
      out_pos_r <= res_pos_r;
      out_cnt_r <= cnt_ext[CNT_W-1:0];
    end
  end

  assign out_ok             = out_ok_r;
  assign out_found_position = out_pos_r;
  assign out_count          = out_cnt_r;

endmodule

@@ sv/pl_ctrl.sv @@
module pl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pl_pkg::pl_status_t st,
  output pl_pkg::pl_cmd_t    cmd
);
  import pl_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;

  // Sequence one operation; finish waits for a free output register
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        case (st.op)
          FUNC_SEARCH: begin
            if (st.cnt_zero) begin
              cmd.res_set = 1'b1;
              state_nxt   = ST_FINISH;
            end else begin
              cmd.idx_set = 1'b1;
              cmd.idx_sel = IDX_ZERO;
              state_nxt   = ST_SRCH_RD;
            end
          end
          FUNC_INSERT: begin
            if (!st.ins_ok) begin
              cmd.res_set = 1'b1;
              state_nxt   = ST_FINISH;
            end else begin
              cmd.idx_set = 1'b1;
              cmd.idx_sel = IDX_COUNT;
              state_nxt   = ST_INS_CHK;
            end
          end
          FUNC_DELETE: begin
            if (!st.del_ok) begin
              cmd.res_set = 1'b1;
              state_nxt   = ST_FINISH;
            end else begin
              cmd.idx_set = 1'b1;
              cmd.idx_sel = IDX_POS;
              state_nxt   = ST_DEL_CHK;
            end
          end
          default: begin
            cmd.res_set = 1'b1;
            state_nxt   = ST_FINISH;
          end
        endcase
      end
      ST_SRCH_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_HERE;
        state_nxt  = ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        if (st.hit) begin
          cmd.res_set   = 1'b1;
          cmd.res_ok    = 1'b1;
          cmd.res_found = 1'b1;
          state_nxt     = ST_FINISH;
        end else if (st.idx_last) begin
          cmd.res_set = 1'b1;
          state_nxt   = ST_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_SRCH_RD;
        end
      end
      ST_INS_CHK: begin
        if (st.idx_at_pos) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = WR_VALUE;
          cmd.cnt_inc = 1'b1;
          cmd.res_set = 1'b1;
          cmd.res_ok  = 1'b1;
          state_nxt   = ST_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_DOWN;
          state_nxt  = ST_INS_WR;
        end
      end
      ST_INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_READ;
        cmd.idx_dec = 1'b1;
        state_nxt   = ST_INS_CHK;
      end
      ST_DEL_CHK: begin
        if (st.idx_last) begin
          cmd.cnt_dec = 1'b1;
          cmd.res_set = 1'b1;
          cmd.res_ok  = 1'b1;
          state_nxt   = ST_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_UP;
          state_nxt  = ST_DEL_WR;
        end
      end
      ST_DEL_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_READ;
        cmd.idx_inc = 1'b1;
        state_nxt   = ST_DEL_CHK;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Raise valid on load, drop it once the beat is taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

@@ sv/positional_list_insert_delete_search.sv @@
// Ordered list of signed 32-bit values with search, insert and delete.
// in_ch carries one operation per beat (func, position, value); out_ch returns
// one result per operation (ok, found_position, count), in order.
// Both channels use valid/ready; a beat moves when both are high.
// Steps, with n the count before the operation and p the position:
//   accept, decide and finish, plus the walk:
//   search: a read and a compare per entry examined, up to n entries
//   insert: n-p moves and a write, delete: n-p-1 moves, refused or unused code: none.
// The walk moves one entry at a time through the entry store, which has one
// read and one write port (read registered, then written back one place on).
// A new operation is taken only after the previous one has reached the
// output register; while out_ch is stalled the result there holds, the next
// operation is still taken and computed, and waits in its finish step.
// Reset empties the list (count zero) at once; the entry store is not
// cleared, as entries are only read below the count.
module positional_list_insert_delete_search #(
  parameter int DEPTH = 128
) (
  input  logic     clk,
  input  logic     rst_n,
  pl_in_if.sink    in_ch,
  pl_out_if.source out_ch
);
  import pl_pkg::*;

  pl_cmd_t    cmd;
  pl_status_t st;

  pl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  pl_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_func            (in_ch.func),
    .in_position        (in_ch.position),
    .in_value           (in_ch.value),
    .out_ok             (out_ch.ok),
    .out_found_position (out_ch.found_position),
    .out_count          (out_ch.count)
  );

endmodule

@@ sim/pl_result_checker.sv @@
`timescale 1ns / 100ps

module pl_result_checker
  import pl_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic clk,
  input  logic rst_n,
  pl_in_if     in_ch,
  pl_out_if    out_ch,
  output int   fail_count,
  output int   results_due
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef struct packed {
    logic              ok;
    logic [FPOS_W-1:0] found_pos;
    logic [CNT_W-1:0]  count;
  } list_result_t;

  // Mirror of the list contents and length
  logic [VAL_W-1:0] mirror_entries [DEPTH];
  logic [CNT_W-1:0] mirror_len;
  list_result_t     due_q [$];

  // Apply one operation to the mirror and return the answer it should give
  function automatic list_result_t apply_list_op(logic [FUNC_W-1:0] func,
                                                 logic [POS_W-1:0]  pos,
                                                 logic [VAL_W-1:0]  val);
    list_result_t res;
    int           i;
    int           len;
    int           at;
    res = '0;
    len = int'(mirror_len);
    at  = int'(pos);
    case (func_t'(func))
      FUNC_SEARCH: begin
        for (i = 0; i < len; i++) begin
          if (mirror_entries[IW'(i)] == val) begin
            res.ok        = 1'b1;
            res.found_pos = FPOS_W'(i);
            break;
          end
        end
      end
      FUNC_INSERT: begin
        if (len < DEPTH && at <= len) begin
          for (i = len; i > at; i--) begin
            mirror_entries[IW'(i)] = mirror_entries[IW'(i - 1)];
          end
          mirror_entries[IW'(at)] = val;
          mirror_len++;
          res.ok = 1'b1;
        end
      end
      FUNC_DELETE: begin
        if (len != 0 && at < len) begin
          for (i = at; i + 1 < len; i++) begin
            mirror_entries[IW'(i)] = mirror_entries[IW'(i + 1)];
          end
          mirror_len--;
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.count = mirror_len;
    return res;
  endfunction

  // Watch both channels: compare each result beat, then predict the new operation
  always @(posedge clk) begin : watch
    list_result_t want;
    if (!rst_n) begin
      mirror_len = '0;
      due_q.delete();
      results_due <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_q.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing due: expected none, %s%0d pos=%0d count=%0d",
                   $time, "got ok=", out_ch.ok, out_ch.found_position, out_ch.count);
        end else begin
          want = due_q.pop_front();
          if (out_ch.ok !== want.ok) begin
            fail_count++;
            $display("%0t: ok mismatch: expected %0d, got %0d", $time, want.ok, out_ch.ok);
          end
          if (out_ch.found_position !== want.found_pos) begin
            fail_count++;
            $display("%0t: found_position mismatch: expected %0d, got %0d",
                     $time, want.found_pos, out_ch.found_position);
          end
          if (out_ch.count !== want.count) begin
            fail_count++;
            $display("%0t: count mismatch: expected %0d, got %0d",
                     $time, want.count, out_ch.count);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        due_q.push_back(apply_list_op(in_ch.func, in_ch.position, in_ch.value));
      results_due <= due_q.size();
    end
  end

endmodule

@@ sim/positional_list_insert_delete_search_test.sv @@
`timescale 1ns / 100ps

module positional_list_insert_delete_search_test;
  import pl_pkg::*;

  localparam int               LIST_DEPTH  = 128;
  localparam int               SEG_ITEMS   = 100;
  localparam int               NUM_SEGS    = 8;
  localparam int               HOLD_CYCLES = 400;
  localparam int               TAIL_CYCLES = 300;
  localparam int               CYCLE_LIMIT = 2000000;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} op_mix_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   results_due;
  int   src_idle;
  int   snk_idle;
  int   hold_seq;
  int   hold_seen;
  int   hold_left;
  int   est_len;

  pl_in_if  in_ch ();
  pl_out_if out_ch ();

  positional_list_insert_delete_search #(
    .DEPTH (LIST_DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pl_result_checker #(
    .DEPTH (LIST_DEPTH)
  ) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up on a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_seen    <= 0;
      hold_left    <= 0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_seq != hold_seen) begin
      hold_seen    <= hold_seq;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(9) < 4) begin
      case ($urandom_range(7))
        0:       return 32'h0000_0000;
        1:       return 32'hFFFF_FFFF;
        2:       return 32'h8000_0000;
        3:       return 32'h7FFF_FFFF;
        4:       return 32'h0000_0001;
        5:       return 32'h5555_5555;
        6:       return 32'hAAAA_AAAA;
        default: return 32'h0000_0007;
      endcase
    end
    return $urandom;
  endfunction

  // Offer one beat after a random gap; hold it until taken
  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= func;
    in_ch.position <= pos;
    in_ch.value    <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // Track the rough length to steer later positions
    if (func == FUNC_INSERT && est_len < LIST_DEPTH && int'(pos) <= est_len) est_len++;
    else if (func == FUNC_DELETE && int'(pos) < est_len) est_len--;
  endtask

  task automatic send_random(input op_mix_t mix);
    int                r;
    logic [FUNC_W-1:0] f;
    logic [POS_W-1:0]  p;
    logic [POS_W-1:0]  ins_pos;
    logic [POS_W-1:0]  del_pos;
    r       = $urandom_range(99);
    ins_pos = (est_len < LIST_DEPTH) ? POS_W'($urandom_range(est_len, 0))
                                     : POS_W'($urandom_range(128, 0));
    del_pos = (est_len > 0) ? POS_W'($urandom_range(est_len - 1, 0)) : '0;
    // Fold the mix into insert / delete / search / noise bands
    if (mix == MIX_EVEN) begin
      if (r < 35)      r = 0;
      else if (r < 70) r = 1;
      else if (r < 90) r = 2;
      else             r = 3;
    end else begin
      if (r < 70)      r = (mix == MIX_GROW) ? 0 : 1;
      else if (r < 80) r = 2;
      else if (r < 90) r = (mix == MIX_GROW) ? 1 : 0;
      else             r = 3;
    end
    case (r)
      0: begin f = FUNC_INSERT; p = ins_pos; end
      1: begin f = FUNC_DELETE; p = del_pos; end
      2: begin f = FUNC_SEARCH; p = POS_W'($urandom_range(128, 0)); end
      default: begin
        // Noise: unused code, insert past the end, delete at or past the end
        case ($urandom_range(2))
          0: begin f = FUNC_UNUSED; p = POS_W'($urandom_range(128, 0)); end
          1: begin
            f = FUNC_INSERT;
            p = (est_len < LIST_DEPTH) ? POS_W'($urandom_range(128, est_len + 1))
                                       : POS_W'($urandom_range(128, 0));
          end
          default: begin f = FUNC_DELETE; p = POS_W'($urandom_range(128, est_len)); end
        endcase
      end
    endcase
    send_item(f, p, pick_value());
  endtask

  // Drop valid and hold until every due result has come back
  task automatic wait_results_home();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  initial begin
    op_mix_t seg_mix [NUM_SEGS];
    seg_mix = '{MIX_GROW, MIX_GROW, MIX_GROW, MIX_EVEN,
                MIX_SHRINK, MIX_SHRINK, MIX_SHRINK, MIX_EVEN};
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.func     = FUNC_SEARCH;
    in_ch.position = '0;
    in_ch.value    = '0;
    src_idle       = 0;
    snk_idle       = 0;
    hold_seq       = 0;
    est_len        = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, extremes of value, ends and middle, refusals
    send_item(FUNC_SEARCH, 8'd0, 32'h0000_0000);
    send_item(FUNC_DELETE, 8'd0, 32'hFFFF_FFFF);
    send_item(FUNC_INSERT, 8'd1, 32'h1234_5678);
    send_item(FUNC_UNUSED, 8'd0, 32'h0000_0000);
    send_item(FUNC_INSERT, 8'd0, 32'h7FFF_FFFF);
    send_item(FUNC_INSERT, 8'd0, 32'h8000_0000);
    send_item(FUNC_INSERT, 8'd2, 32'hFFFF_FFFF);
    send_item(FUNC_INSERT, 8'd1, 32'h0000_0000);
    send_item(FUNC_INSERT, 8'd128, 32'h5555_5555);
    send_item(FUNC_SEARCH, 8'd0, 32'h8000_0000);
    send_item(FUNC_SEARCH, 8'd77, 32'hFFFF_FFFF);
    send_item(FUNC_SEARCH, 8'd0, 32'h0000_3039);
    send_item(FUNC_INSERT, 8'd2, 32'h7FFF_FFFF);
    send_item(FUNC_SEARCH, 8'd0, 32'h7FFF_FFFF);
    send_item(FUNC_DELETE, 8'd5, 32'h0000_0000);
    send_item(FUNC_DELETE, 8'd4, 32'hAAAA_AAAA);
    send_item(FUNC_DELETE, 8'd0, 32'h0000_0000);
    send_item(FUNC_DELETE, 8'd1, 32'h0000_0000);
    send_item(FUNC_UNUSED, 8'd128, 32'hFFFF_FFFF);
    send_item(FUNC_SEARCH, 8'd128, 32'h0000_0000);
    send_item(FUNC_DELETE, 8'd128, 32'h0000_0000);
    send_item(FUNC_SEARCH, 8'd0, 32'h7FFF_FFFF);
    wait_results_home();

    // Random segments: fill to full, churn, drain to empty, churn
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg % 4)
        0:       begin src_idle = 0;  snk_idle = 0;  end
        1:       begin src_idle = 78; snk_idle = 0;  end
        2:       begin src_idle = 0;  snk_idle = 78; end
        default: begin src_idle = 36; snk_idle = 36; end
      endcase
      // Long receiver hold-off while the sender keeps offering
      if (seg == 4) hold_seq++;
      for (int k = 0; k < SEG_ITEMS; k++) send_random(seg_mix[seg]);
      wait_results_home();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ positional_list_insert_delete_search.f @@
sv/pl_pkg.sv
sv/pl_if.sv
sv/pl_dpath.sv
sv/pl_ctrl.sv
sv/positional_list_insert_delete_search.sv
sim/pl_result_checker.sv
sim/positional_list_insert_delete_search_test.sv
